>>> rtl/core/rhh_pkg.sv
// Package for the Robin Hood hash table: sizes, op and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package rhh_pkg;

	localparam int SLOTS     = 1024;
	localparam int IDX_W     = $clog2(SLOTS);
	localparam int DIST_W    = IDX_W;
	localparam int CNT_W     = IDX_W + 1;
	localparam int META_W    = DIST_W + 1;
	localparam int LIM_W     = 9;
	localparam int FILL_SH   = 8;
	localparam int FULL_W    = CNT_W + LIM_W + 1;
	localparam logic [63:0] HASH_MUL = 64'h9e3779b97f4a7c15;
	localparam logic [LIM_W-1:0] LOAD_RESET = LIM_W'(192);

	localparam logic [1:0] OP_GET   = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_DEL   = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] RS_FOUND    = 2'd0;
	localparam logic [1:0] RS_INSERTED = 2'd1;
	localparam logic [1:0] RS_MISSING  = 2'd2;
	localparam logic [1:0] RS_FULL     = 2'd3;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_LK_RD, S_LK_EV, S_DL_RD, S_DL_EV, S_IN_RD, S_IN_EV, S_RESP
	} state_t;

	typedef enum logic [3:0] {
		A_NONE, A_LOAD, A_STEP, A_SET_UPD, A_INS_START, A_INS_PLACE, A_INS_SWAP,
		A_DEL_START, A_DEL_MOVE, A_DEL_END, A_CLR_STEP
	} dp_act_t;

	typedef struct packed {
		dp_act_t    act;
		logic       out_load;
		logic [1:0] out_status;
		logic       out_hit;
	} cmd_t;

	typedef struct packed {
		logic rd_valid;
		logic key_match;
		logic dist_gt;
		logic dist_zero;
		logic n_last;
		logic clr_last;
		logic full;
	} stat_t;

endpackage

>>> rtl/core/rhh_datapath.sv
// Datapath of the hash table: slot memories, probe registers, fill count,
// load limit register and the result word registers.
// Depends on rhh_pkg.
module rhh_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [63:0]           key_in,
	input  logic [63:0]           value_in,
	input  logic                  cfg_we,
	input  logic [rhh_pkg::LIM_W-1:0] cfg_data,
	input  rhh_pkg::cmd_t         cmd,
	output rhh_pkg::stat_t        stat,
	output logic [1:0]            status,
	output logic [63:0]           value_out,
	output logic [rhh_pkg::CNT_W-1:0] entry_count
);
	import rhh_pkg::*;

	logic [63:0]     key_mem  [SLOTS];
	logic [63:0]     val_mem  [SLOTS];
	logic [META_W-1:0] meta_mem [SLOTS];

	logic [63:0]       rd_key_q, rd_val_q;
	logic [META_W-1:0] rd_meta_q;

	logic [63:0]       key_q, val_q;
	logic [IDX_W-1:0]  idx_q, wr_i_q, n_q, ptr_q;
	logic [DIST_W-1:0] dist_q;
	logic [CNT_W-1:0]  count_q;
	logic [LIM_W-1:0]  limit_q;
	logic [1:0]        status_q;
	logic [63:0]       vout_q;
	logic [CNT_W-1:0]  ecount_q;

	logic              key_we, val_we, meta_we;
	logic [IDX_W-1:0]  key_wa, val_wa, meta_wa;
	logic [63:0]       key_wd, val_wd;
	logic [META_W-1:0] meta_wd;

	logic [DIST_W-1:0] rd_dist;
	logic [FULL_W-1:0] fill_next, fill_max;

	function automatic logic [IDX_W-1:0] home_of(input logic [63:0] k);
		logic [IDX_W-1:0]   x;
		logic [2*IDX_W-1:0] p;
		begin
			// low bits of the hash only need low bits of both operands
			x = k[IDX_W-1:0] ^ k[IDX_W+31:32];
			p = x * HASH_MUL[IDX_W-1:0];
			home_of = p[IDX_W-1:0];
		end
	endfunction

	assign rd_dist   = rd_meta_q[DIST_W-1:0];
	assign fill_next = FULL_W'(count_q + CNT_W'(1)) << FILL_SH;
	assign fill_max  = FULL_W'(SLOTS) * FULL_W'(limit_q);

	always_comb begin
		stat.rd_valid  = rd_meta_q[META_W-1];
		stat.key_match = rd_key_q == key_q;
		stat.dist_gt   = dist_q > rd_dist;
		stat.dist_zero = rd_dist == '0;
		stat.n_last    = n_q == '1;
		stat.clr_last  = ptr_q == '1;
		stat.full      = (count_q >= CNT_W'(SLOTS)) || (fill_next > fill_max);
	end

	always_comb begin
		key_we = 1'b0; val_we = 1'b0; meta_we = 1'b0;
		key_wa = idx_q; val_wa = idx_q; meta_wa = idx_q;
		key_wd = key_q; val_wd = val_q; meta_wd = {1'b1, dist_q};
		unique case (cmd.act)
			A_SET_UPD: begin
				val_we = 1'b1;
			end
			A_INS_PLACE, A_INS_SWAP: begin
				key_we = 1'b1; val_we = 1'b1; meta_we = 1'b1;
			end
			A_DEL_MOVE: begin
				key_we = 1'b1; val_we = 1'b1; meta_we = 1'b1;
				key_wa = wr_i_q; val_wa = wr_i_q; meta_wa = wr_i_q;
				key_wd = rd_key_q; val_wd = rd_val_q;
				meta_wd = {1'b1, rd_dist - DIST_W'(1)};
			end
			A_DEL_END: begin
				meta_we = 1'b1; meta_wa = wr_i_q; meta_wd = '0;
			end
			A_CLR_STEP: begin
				meta_we = 1'b1; meta_wa = ptr_q; meta_wd = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we) key_mem[key_wa] <= key_wd;
		if (val_we) val_mem[val_wa] <= val_wd;
		if (meta_we) meta_mem[meta_wa] <= meta_wd;
		rd_key_q  <= key_mem[idx_q];
		rd_val_q  <= val_mem[idx_q];
		rd_meta_q <= meta_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		unique case (cmd.act)
			A_LOAD: begin
				key_q <= key_in; val_q <= value_in;
				idx_q <= home_of(key_in); dist_q <= '0; n_q <= '0;
			end
			A_STEP: begin
				idx_q <= idx_q + IDX_W'(1); dist_q <= dist_q + DIST_W'(1);
				n_q <= n_q + IDX_W'(1);
			end
			A_INS_START: begin
				idx_q <= home_of(key_q); dist_q <= '0;
			end
			A_INS_SWAP: begin
				// carry the evicted word on with its own distance
				key_q <= rd_key_q; val_q <= rd_val_q;
				dist_q <= rd_dist + DIST_W'(1); idx_q <= idx_q + IDX_W'(1);
			end
			A_DEL_START: begin
				wr_i_q <= idx_q; idx_q <= idx_q + IDX_W'(1); n_q <= '0;
			end
			A_DEL_MOVE: begin
				wr_i_q <= idx_q; idx_q <= idx_q + IDX_W'(1); n_q <= n_q + IDX_W'(1);
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			status_q <= cmd.out_status;
			vout_q   <= cmd.out_hit ? rd_val_q : 64'd0;
			ecount_q <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			count_q <= '0;
			limit_q <= LOAD_RESET;
		end else begin
			if (cfg_we) limit_q <= cfg_data;
			unique case (cmd.act)
				A_CLR_STEP: begin
					ptr_q <= ptr_q + IDX_W'(1);
					if (ptr_q == '1) count_q <= '0;
				end
				A_INS_PLACE: count_q <= count_q + CNT_W'(1);
				A_DEL_END: if (count_q != '0) count_q <= count_q - CNT_W'(1);
				default: begin
				end
			endcase
		end
	end

	assign status      = status_q;
	assign value_out   = vout_q;
	assign entry_count = ecount_q;

endmodule

>>> rtl/core/rhh_ctrl.sv
// Controller of the hash table: sequences lookup, insert, delete and clear
// over the datapath and runs both handshakes.
// Depends on rhh_pkg.
module rhh_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     op,
	output logic           out_valid,
	input  logic           out_ready,
	input  rhh_pkg::stat_t stat,
	output rhh_pkg::cmd_t  cmd
);
	import rhh_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] op_q, resp_q, resp_d;
	logic       hit_q, hit_d, set_resp;
	logic       clr_op_q, out_valid_q, out_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			op_q        <= OP_GET;
			resp_q      <= RS_FOUND;
			hit_q       <= 1'b0;
			clr_op_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				op_q     <= op;
				clr_op_q <= op == OP_CLEAR;
			end
			if (set_resp) begin
				resp_q <= resp_d;
				hit_q  <= hit_d;
			end
			if (out_fire) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '{act: A_NONE, out_load: 1'b0, out_status: resp_q, out_hit: hit_q};
		in_ready = 1'b0;
		out_fire = 1'b0;
		set_resp = 1'b0;
		resp_d   = RS_FOUND;
		hit_d    = 1'b0;
		unique case (state_q)
			S_CLR: begin
				cmd.act = A_CLR_STEP;
				if (stat.clr_last) begin
					state_d  = clr_op_q ? S_RESP : S_IDLE;
					set_resp = 1'b1;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.act = A_LOAD;
					state_d = (op == OP_CLEAR) ? S_CLR : S_LK_RD;
				end
			end
			S_LK_RD: state_d = S_LK_EV;
			S_LK_EV: begin
				if (stat.rd_valid && stat.key_match) begin
					set_resp = 1'b1;
					unique case (op_q)
						OP_GET: begin hit_d = 1'b1; state_d = S_RESP; end
						OP_SET: begin cmd.act = A_SET_UPD; state_d = S_RESP; end
						OP_DEL: begin cmd.act = A_DEL_START; state_d = S_DL_RD; end
						default: state_d = S_RESP;
					endcase
				end else if (!stat.rd_valid || stat.dist_gt || stat.n_last) begin
					set_resp = 1'b1;
					if (op_q != OP_SET) begin
						resp_d  = RS_MISSING;
						state_d = S_RESP;
					end else if (stat.full) begin
						resp_d  = RS_FULL;
						state_d = S_RESP;
					end else begin
						resp_d  = RS_INSERTED;
						cmd.act = A_INS_START;
						state_d = S_IN_RD;
					end
				end else begin
					cmd.act = A_STEP;
					state_d = S_LK_RD;
				end
			end
			S_DL_RD: state_d = S_DL_EV;
			S_DL_EV: begin
				// stop the back shift at an empty slot, a word at its home or the last probe
				if (!stat.rd_valid || stat.dist_zero || stat.n_last) begin
					cmd.act = A_DEL_END;
					state_d = S_RESP;
				end else begin
					cmd.act = A_DEL_MOVE;
					state_d = S_DL_RD;
				end
			end
			S_IN_RD: state_d = S_IN_EV;
			S_IN_EV: begin
				state_d = S_IN_RD;
				if (!stat.rd_valid) begin
					cmd.act = A_INS_PLACE;
					state_d = S_RESP;
				end else if (stat.dist_gt) begin
					cmd.act = A_INS_SWAP;
				end else begin
					cmd.act = A_STEP;
				end
			end
			S_RESP: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_fire     = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !in_ready)
		else $error("input accepted during clear sweep");

	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_RESP)
		else $error("result raised outside response state");

	a_lookup_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && op != OP_CLEAR) |=> state_q == S_LK_RD)
		else $error("accepted word did not start a lookup");

endmodule

>>> rtl/core/robin_hood_hash_table.sv
// Robin Hood hash table, 1024 slots of 64-bit key and 64-bit value.
// Channels: request word (op, key, value) on in_valid/in_ready, result word
// (status, value_out, entry_count) on out_valid/out_ready, and a load_limit
// register written by cfg_we/cfg_data; the user is to write it only while
// idle, which the block itself does not enforce. Each request is taken one
// at a time. A lookup reads each probed slot (registered memory read, then
// compare) between accepting and answering the request. Insert then walks
// again from home to the empty slot in the same way; delete shifts each word
// back in the same way and reads the slot that ends the shift. Clear sweeps
// the slot metadata memory, one slot a cycle. After reset the same sweep runs
// before the first request is accepted; configuration writes are taken during it.
// A finished result sits in an output register; the next request is accepted
// while it waits. If the receiver stalls, the following result holds the
// block in its answer state until the register is taken.
// Depends on rhh_pkg, rhh_ctrl, rhh_datapath.
module robin_hood_hash_table (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            op,
	input  logic signed [63:0]    key,
	input  logic signed [63:0]    value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic signed [63:0]    value_out,
	output logic [rhh_pkg::CNT_W-1:0] entry_count,
	input  logic                  cfg_we,
	input  logic [rhh_pkg::LIM_W-1:0] cfg_data
);
	import rhh_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	rhh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rhh_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.key_in      (key),
		.value_in    (value),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.stat        (stat),
		.status      (status),
		.value_out   (value_out),
		.entry_count (entry_count)
	);

endmodule

>>> sim/tb.sv
// Testbench for robin_hood_hash_table: a behavioral copy of the Robin Hood map
// predicts each result word, which is checked in order against the block's output.
// Depends on rhh_pkg and the RTL of robin_hood_hash_table.
`timescale 1ns / 1ps

module tb;
	import rhh_pkg::*;

	localparam int MAX_CYCLES = 12_000_000;
	localparam int SETTLE = 40;

	typedef struct {
		logic [1:0]       status;
		logic [63:0]      value_out;
		logic [CNT_W-1:0] entry_count;
	} result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            op;
	logic signed [63:0]    key;
	logic signed [63:0]    value;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [1:0]            status;
	logic signed [63:0]    value_out;
	logic [CNT_W-1:0]      entry_count;
	logic                  cfg_we;
	logic [LIM_W-1:0]      cfg_data;

	// shadow of the table
	logic [63:0]      map_key [SLOTS];
	logic [63:0]      map_val [SLOTS];
	logic             map_used [SLOTS];
	int unsigned      map_dist [SLOTS];
	int unsigned      map_count;
	logic [LIM_W-1:0] map_limit;

	result_t     pending[$];
	int          mismatches = 0;
	int          cycles = 0;
	bit          idle_on;
	int          stall_left = 0;
	logic [63:0] key_pool [160];

	robin_hood_hash_table i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.value_out  (value_out),
		.entry_count(entry_count),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned home_of(logic [63:0] k);
		logic [63:0] x;
		logic [63:0] h;
		x = k ^ 64'($signed(k) >>> 32);
		h = x * HASH_MUL;
		return int'(h[IDX_W-1:0]);
	endfunction

	function automatic int find_slot(logic [63:0] k);
		int unsigned i;
		int unsigned d;
		i = home_of(k);
		d = 0;
		for (int n = 0; n < SLOTS; n++) begin
			if (!map_used[i])
				return -1;
			if (map_key[i] == k)
				return int'(i);
			if (d > map_dist[i])
				return -1;
			d++;
			i = (i + 1) % SLOTS;
		end
		return -1;
	endfunction

	function automatic void place_new(logic [63:0] k, logic [63:0] v);
		int unsigned i;
		int unsigned d;
		logic [63:0] tk;
		logic [63:0] tv;
		int unsigned td;
		i = home_of(k);
		d = 0;
		for (int n = 0; n < SLOTS; n++) begin
			if (!map_used[i]) begin
				map_key[i] = k;
				map_val[i] = v;
				map_used[i] = 1'b1;
				map_dist[i] = d;
				map_count++;
				return;
			end
			// the richer resident gives way and keeps its own distance
			if (d > map_dist[i]) begin
				tk = map_key[i];
				tv = map_val[i];
				td = map_dist[i];
				map_key[i] = k;
				map_val[i] = v;
				map_dist[i] = d;
				k = tk;
				v = tv;
				d = td;
			end
			d++;
			i = (i + 1) % SLOTS;
		end
	endfunction

	function automatic void shift_out(int unsigned i);
		int unsigned j;
		j = (i + 1) % SLOTS;
		for (int n = 0; n < SLOTS; n++) begin
			if (!map_used[j] || map_dist[j] == 0)
				break;
			map_key[i] = map_key[j];
			map_val[i] = map_val[j];
			map_used[i] = 1'b1;
			map_dist[i] = map_dist[j] - 1;
			i = j;
			j = (j + 1) % SLOTS;
		end
		map_used[i] = 1'b0;
		map_dist[i] = 0;
		if (map_count > 0)
			map_count--;
	endfunction

	function automatic result_t apply_request(logic [1:0] o, logic [63:0] k, logic [63:0] v);
		result_t r;
		int at;
		r.status = RS_FOUND;
		r.value_out = '0;
		at = (o == OP_CLEAR) ? -1 : find_slot(k);
		case (o)
			OP_GET: begin
				if (at >= 0)
					r.value_out = map_val[at];
				else
					r.status = RS_MISSING;
			end
			OP_SET: begin
				if (at >= 0)
					map_val[at] = v;
				else if (map_count >= SLOTS ||
						longint'(map_count + 1) * 256 > longint'(SLOTS) * longint'(map_limit))
					r.status = RS_FULL;
				else begin
					place_new(k, v);
					r.status = RS_INSERTED;
				end
			end
			OP_DEL: begin
				if (at >= 0)
					shift_out(at);
				else
					r.status = RS_MISSING;
			end
			default: begin
				for (int s = 0; s < SLOTS; s++) begin
					map_used[s] = 1'b0;
					map_dist[s] = 0;
				end
				map_count = 0;
			end
		endcase
		r.entry_count = CNT_W'(map_count);
		return r;
	endfunction

	task automatic send_req(input logic [1:0] o, input logic [63:0] k, input logic [63:0] v);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		key <= k;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending.push_back(apply_request(o, k, v));
	endtask

	// hold the request line low and let every result drain before a register write
	task automatic drain;
		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIM_W-1:0] lim);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		map_limit = lim;
	endtask

	function automatic logic [63:0] key_near(int unsigned lo, int unsigned hi);
		logic [63:0] k;
		do
			k = {$urandom, $urandom};
		while (home_of(k) < lo || home_of(k) > hi);
		return k;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic test_directed;
		logic [63:0] c0, c1, c2;
		c0 = key_near(1023, 1023);
		c1 = key_near(1023, 1023);
		c2 = key_near(1022, 1023);
		send_req(OP_GET, 64'h8000_0000_0000_0000, 64'd0);
		send_req(OP_SET, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
		send_req(OP_SET, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000);
		send_req(OP_SET, 64'd0, 64'hffff_ffff_ffff_ffff);
		send_req(OP_SET, 64'hffff_ffff_ffff_ffff, 64'd0);
		send_req(OP_GET, 64'h8000_0000_0000_0000, 64'd0);
		send_req(OP_SET, 64'd0, 64'h1234_5678_9abc_def0);
		send_req(OP_GET, 64'd0, 64'hdead_beef);
		// colliding keys at the top slot force wrap and displacement
		send_req(OP_SET, c0, 64'd1);
		send_req(OP_SET, c1, 64'd2);
		send_req(OP_SET, c2, 64'd3);
		send_req(OP_GET, c1, 64'd0);
		send_req(OP_DEL, c0, 64'd0);
		send_req(OP_GET, c2, 64'd0);
		send_req(OP_DEL, c0, 64'd0);
		send_req(OP_DEL, 64'hffff_ffff_ffff_ffff, 64'd0);
		send_req(OP_GET, 64'hffff_ffff_ffff_ffff, 64'd0);
		send_req(OP_CLEAR, 64'd0, 64'd0);
		send_req(OP_GET, 64'd0, 64'd0);
		send_req(OP_CLEAR, rand64(), rand64());
	endtask

	task automatic test_load_limit;
		write_limit(LIM_W'(1));
		for (int n = 0; n < 6; n++)
			send_req(OP_SET, 64'(n * 77 + 5), rand64());
		send_req(OP_SET, 64'd5, 64'd99);
		write_limit('0);
		send_req(OP_SET, 64'd4242, 64'd1);
		send_req(OP_GET, 64'd5, 64'd0);
		send_req(OP_CLEAR, 64'd0, 64'd0);
		send_req(OP_SET, 64'd4242, 64'd1);
	endtask

	// fill up to a limit of 32 words, then update, miss, delete and refill
	task automatic test_full_table;
		write_limit(LIM_W'(8));
		for (int n = 0; n < 36; n++)
			send_req(OP_SET, 64'(n) * 64'h0000_0001_0000_0003, 64'(n));
		send_req(OP_SET, 64'd0, 64'd77);
		send_req(OP_GET, 64'h7777_7777_7777_7777, 64'd0);
		send_req(OP_GET, 64'd31 * 64'h0000_0001_0000_0003, 64'd0);
		for (int n = 0; n < 8; n++)
			send_req(OP_DEL, 64'(n * 5) * 64'h0000_0001_0000_0003, 64'd0);
		send_req(OP_SET, 64'h1111, 64'd5);
		send_req(OP_CLEAR, 64'd0, 64'd0);
	endtask

	task automatic test_random_traffic;
		logic [LIM_W-1:0] limits [5];
		logic [63:0] k;
		int unsigned pick;
		limits = '{LIM_W'(256), LIM_W'(3), LIM_W'(192), LIM_W'(511),
			LIM_W'($urandom_range(1, 256))};
		for (int i = 0; i < 160; i++)
			key_pool[i] = (i < 40) ? key_near(1016, 1023) : (i < 60) ? key_near(0, 5) : rand64();
		for (int ph = 0; ph < 5; ph++) begin
			write_limit(limits[ph]);
			idle_on = (ph != 4);
			for (int n = 0; n < 114; n++) begin
				k = ($urandom_range(0, 9) == 0) ? rand64() : key_pool[$urandom_range(0, 159)];
				pick = $urandom_range(0, 99);
				if (pick < 45)
					send_req(OP_SET, k, rand64());
				else if (pick < 72)
					send_req(OP_GET, k, rand64());
				else if (pick < 98)
					send_req(OP_DEL, k, rand64());
				else
					send_req(OP_CLEAR, k, rand64());
			end
		end
	endtask

	// result side: random stall bursts, compare against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		cycles <= cycles + 1;
		if (out_valid && out_ready) begin
			if (pending.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result word: status %0d value_out %h entry_count %0d",
						status, value_out, entry_count);
				mismatches <= mismatches + 1;
			end else begin
				want = pending.pop_front();
				if (want.status !== status || want.value_out !== value_out ||
						want.entry_count !== entry_count) begin
					if (mismatches < 10)
						$display("result mismatch: exp %0d/%h/%0d got %0d/%h/%0d",
							want.status, want.value_out, want.entry_count,
							status, value_out, entry_count);
					mismatches <= mismatches + 1;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= (stall_left == 1);
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(1, 3);
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		if (cycles > MAX_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		in_valid = 1'b0;
		op = OP_GET;
		key = '0;
		value = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		idle_on = 1'b1;
		map_count = 0;
		map_limit = LOAD_RESET;
		for (int s = 0; s < SLOTS; s++) begin
			map_used[s] = 1'b0;
			map_dist[s] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_load_limit();
		test_full_table();
		test_random_traffic();
		drain();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/rhh_pkg.sv
rtl/core/rhh_datapath.sv
rtl/core/rhh_ctrl.sv
rtl/core/robin_hood_hash_table.sv
sim/tb.sv
